// ----- sv/gather_index_pattern_classifier_defines.svh -----
// Assertion macros for the gather index pattern classifier.
`ifndef GATHER_INDEX_PATTERN_CLASSIFIER_DEFINES_SVH
`define GATHER_INDEX_PATTERN_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define GIPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GIPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GIPC_ASSERT_IMP(lbl, ante, cons, msg)
`define GIPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/gipc_pkg.sv -----
package gipc_pkg;

  localparam int LANES       = 8;
  localparam int IDX_W       = 31;
  localparam int CNT_W       = 4;
  localparam int MASK_W      = 16;
  localparam int NIB_W       = 4;
  localparam int NIBBLES     = MASK_W / NIB_W;
  localparam int IN_W        = LANES * IDX_W;
  localparam int OUT_W       = 64;
  localparam int WIN_STEPS   = 2;
  localparam int SORT_STAGES = (LANES + 1) / 2;
  localparam int WIN_STAGES  = LANES / 2;

  localparam logic [CNT_W-1:0] LANES_RESET = CNT_W'(LANES);

  typedef enum logic [1:0] {
    PAT_DISORDER = 2'd0,
    PAT_CONTIG   = 2'd1,
    PAT_EQUAL    = 2'd2
  } pattern_t;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [IDX_W:0]              key_t;
  typedef logic [LANES-1:0][IDX_W-1:0] idx_vec_t;
  typedef logic [LANES-1:0][IDX_W:0]   key_vec_t;

  typedef struct packed {
    idx_vec_t          idx;
    key_vec_t          key;
    logic [CNT_W-1:0]  n;
    pattern_t          pattern;
    logic [LANES-1:0]  chg;
    idx_t              start;
    logic [CNT_W-1:0]  windows;
  } item_t;

  typedef struct packed {
    logic              full_gather;
    logic [MASK_W-1:0] mask_word;
    logic [CNT_W-1:0]  window_count;
    logic [LANES-1:0]  change_mask;
    idx_t              base_index;
    pattern_t          pattern;
  } result_t;

  // One compare-exchange layer of an odd-even transposition sort.
  function automatic key_vec_t sort_layer(key_vec_t k, logic par);
    key_vec_t r;
    r = k;
    for (int i = 0; i < LANES - 1; i++) begin
      if ((i[0] == par) && (k[i] > k[i+1])) begin
        r[i]   = k[i+1];
        r[i+1] = k[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/gather_index_pattern_classifier.sv -----
// Channel  Direction  Beat contents
// in_      slave      tdata: index_0 .. index_7, 31 bits each, lane 0 lowest
// out_     master     tdata: pattern, base_index, change_mask, window_count,
//                            mask_word, full_gather, two zero pad bits
// cfg_     write      wr_data: lanes_in_use
//
// One beat is accepted per cycle when nothing stalls. The pipeline depth is
// set by the eight-layer sort network and the seven-step window chain, at
// most two layers or steps per register stage.
// Reset clears every stage valid bit and sets lanes_in_use to eight.
// A stalled stage holds its beat, and empty stages ahead of it keep filling.
`include "gather_index_pattern_classifier_defines.svh"

module gather_index_pattern_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // index_0 .. index_7 from the lowest bit up
  input  logic [gipc_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // pattern, base_index, change_mask, window_count, mask_word, full_gather
  output logic [gipc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [3:0]                  cfg_wr_data
);
  import gipc_pkg::*;

  localparam int CHAIN   = 1 + SORT_STAGES + WIN_STAGES;
  localparam int RES_W   = $bits(result_t);
  localparam int OUT_PAD = OUT_W - RES_W;

  logic [3:0] lanes_in_use_r;
  logic       stg_valid [CHAIN];
  logic       stg_ready [CHAIN];
  item_t      stg_item  [CHAIN];
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_in_use_r <= LANES_RESET;
    end else if (cfg_wr_en) begin
      lanes_in_use_r <= cfg_wr_data;
    end
  end

  gipc_cmp_stage u_cmp (
    .clk          (clk),
    .rst_n        (rst_n),
    .lanes_in_use (lanes_in_use_r),
    .up_valid     (in_tvalid),
    .up_ready     (in_tready),
    .up_idx       (idx_vec_t'(in_tdata)),
    .dn_valid     (stg_valid[0]),
    .dn_ready     (stg_ready[0]),
    .dn_item      (stg_item[0])
  );

  for (genvar g = 0; g < SORT_STAGES; g++) begin : g_sort
    gipc_sort_stage u_sort (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_item  (stg_item[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_item  (stg_item[g+1])
    );
  end

  for (genvar w = 0; w < WIN_STAGES; w++) begin : g_win
    gipc_win_stage #(
      .FIRST_STEP (1 + WIN_STEPS * w)
    ) u_win (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[SORT_STAGES+w]),
      .up_ready (stg_ready[SORT_STAGES+w]),
      .up_item  (stg_item[SORT_STAGES+w]),
      .dn_valid (stg_valid[SORT_STAGES+w+1]),
      .dn_ready (stg_ready[SORT_STAGES+w+1]),
      .dn_item  (stg_item[SORT_STAGES+w+1])
    );
  end

  gipc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[CHAIN-1]),
    .up_ready (stg_ready[CHAIN-1]),
    .up_item  (stg_item[CHAIN-1]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (out_res)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, out_res};

  `GIPC_ASSERT_IMP(a_ordered_fields, out_tvalid && (out_res.pattern != PAT_DISORDER), (out_res.window_count == CNT_W'(1)) && (out_res.mask_word == '0) && !out_res.full_gather, "ordered result carries gather fields")
  `GIPC_ASSERT_IMP(a_full_gather, out_tvalid && out_res.full_gather, out_res.window_count > CNT_W'(1), "full gather flagged with a single window")
  `GIPC_ASSERT_IMP(a_disorder_mask, out_tvalid && (out_res.pattern == PAT_DISORDER), out_res.change_mask == LANES'(1), "disordered result has a change mask")
  `GIPC_ASSERT_NXT(a_cfg_write, cfg_wr_en, lanes_in_use_r == $past(cfg_wr_data), "lane count write lost")

endmodule

// ----- sv/gipc_cmp_stage.sv -----
module gipc_cmp_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           lanes_in_use,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  gipc_pkg::idx_vec_t   up_idx,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output gipc_pkg::item_t      dn_item
);
  import gipc_pkg::*;

  logic             valid_r;
  item_t            item_r;
  item_t            item_nxt;
  logic [CNT_W-1:0] n;
  logic [LANES-1:0] eq;
  logic [LANES-1:0] ok;
  logic [LANES-1:0] rng;

  always_comb begin
    if (lanes_in_use == '0) begin
      n = CNT_W'(1);
    end else if (lanes_in_use > CNT_W'(LANES)) begin
      n = CNT_W'(LANES);
    end else begin
      n = lanes_in_use;
    end
  end

  always_comb begin
    eq  = '1;
    ok  = '1;
    rng = '0;
    for (int i = 0; i < LANES; i++) begin
      rng[i] = CNT_W'(i) < n;
    end
    for (int i = 1; i < LANES; i++) begin
      eq[i] = (up_idx[i] == up_idx[i-1]) || !rng[i];
      ok[i] = eq[i] || (({1'b0, up_idx[i-1]} + (IDX_W+1)'(1)) == {1'b0, up_idx[i]});
    end
  end

  always_comb begin
    item_nxt     = '0;
    item_nxt.idx = up_idx;
    item_nxt.n   = n;
    for (int i = 0; i < LANES; i++) begin
      item_nxt.key[i] = {!rng[i], up_idx[i]};
    end
    item_nxt.chg    = ~eq;
    item_nxt.chg[0] = 1'b1;
    if (&eq) begin
      item_nxt.pattern = PAT_EQUAL;
    end else if (&ok) begin
      item_nxt.pattern = PAT_CONTIG;
    end else begin
      item_nxt.pattern = PAT_DISORDER;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- sv/gipc_sort_stage.sv -----
module gipc_sort_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  gipc_pkg::item_t  up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output gipc_pkg::item_t  dn_item
);
  import gipc_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  always_comb begin
    item_nxt     = up_item;
    item_nxt.key = sort_layer(sort_layer(up_item.key, 1'b0), 1'b1);
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- sv/gipc_win_stage.sv -----
module gipc_win_stage #(
  parameter int FIRST_STEP = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  gipc_pkg::item_t  up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output gipc_pkg::item_t  dn_item
);
  import gipc_pkg::*;

  logic           valid_r;
  item_t          item_r;
  item_t          item_nxt;
  logic [IDX_W:0] limit;

  // Keys arrive sorted; a new window opens at the first key past the current one.
  always_comb begin
    item_nxt = up_item;
    limit    = '0;
    if (FIRST_STEP == 1) begin
      item_nxt.start   = up_item.key[0][IDX_W-1:0];
      item_nxt.windows = CNT_W'(1);
    end
    for (int s = 0; s < WIN_STEPS; s++) begin
      if (FIRST_STEP + s < LANES) begin
        limit = {1'b0, item_nxt.start} + (IDX_W+1)'(item_nxt.n);
        if ((CNT_W'(FIRST_STEP + s) < item_nxt.n) &&
            ({1'b0, item_nxt.key[(FIRST_STEP + s) % LANES][IDX_W-1:0]} >= limit)) begin
          item_nxt.start   = item_nxt.key[(FIRST_STEP + s) % LANES][IDX_W-1:0];
          item_nxt.windows = item_nxt.windows + CNT_W'(1);
        end
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- sv/gipc_out_stage.sv -----
module gipc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  gipc_pkg::item_t    up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output gipc_pkg::result_t  dn_res
);
  import gipc_pkg::*;

  logic              valid_r;
  result_t           res_r;
  result_t           res_nxt;
  idx_t              minv;
  logic              single;
  logic [MASK_W-1:0] packed_offs;
  logic [MASK_W-1:0] n_word;

  always_comb begin
    minv        = up_item.key[0][IDX_W-1:0];
    single      = up_item.windows == CNT_W'(1);
    n_word      = {{(MASK_W-CNT_W){1'b0}}, up_item.n};
    packed_offs = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (CNT_W'(i) < up_item.n) begin
        packed_offs[i*NIB_W +: NIB_W] = up_item.idx[i][NIB_W-1:0] - minv[NIB_W-1:0];
      end
    end
  end

  always_comb begin
    res_nxt.pattern = up_item.pattern;
    if (up_item.pattern != PAT_DISORDER) begin
      res_nxt.base_index   = up_item.idx[0];
      res_nxt.change_mask  = up_item.chg;
      res_nxt.window_count = CNT_W'(1);
      res_nxt.mask_word    = '0;
      res_nxt.full_gather  = 1'b0;
    end else begin
      res_nxt.base_index   = single ? minv : up_item.idx[0];
      res_nxt.change_mask  = LANES'(1);
      res_nxt.window_count = up_item.windows;
      res_nxt.full_gather  = !single;
      if (up_item.n > CNT_W'(NIBBLES)) begin
        res_nxt.mask_word = single ? MASK_W'(1) : n_word;
      end else begin
        res_nxt.mask_word = single ? packed_offs : n_word;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- tb/tb_gather_index_pattern_classifier.sv -----
`timescale 1ns / 1ps

module tb_gather_index_pattern_classifier;
  import gipc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RES_W        = $bits(result_t);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_wr_en = 1'b0;
  logic [3:0]       cfg_wr_data = '0;

  logic [CNT_W-1:0] lanes_cfg = LANES_RESET;
  result_t          pending_results[$];
  int               mismatch_count = 0;
  bit               no_idle = 1'b0;
  int               out_stall_left = 0;

  gather_index_pattern_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic int effective_lanes(logic [CNT_W-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    return n;
  endfunction

  function automatic result_t classify_indices(idx_vec_t v, logic [CNT_W-1:0] cfg);
    result_t          r;
    int               n;
    int               eq_steps;
    int               unit_steps;
    int               windows;
    int               covered;
    int               all_lanes;
    int               offs[LANES];
    longint unsigned  lo;
    longint unsigned  first_lo;
    logic [LANES-1:0] chg;
    n = effective_lanes(cfg);
    eq_steps = 0;
    unit_steps = 0;
    r = '0;
    for (int i = 1; i < n; i++) begin
      if (v[i-1] == v[i]) begin
        eq_steps++;
      end else if (longint'(v[i-1]) + 1 == longint'(v[i])) begin
        unit_steps++;
      end
    end
    if (eq_steps == n - 1 || eq_steps + unit_steps == n - 1) begin
      chg = '0;
      chg[0] = 1'b1;
      for (int i = 1; i < n; i++) begin
        if (v[i] != v[i-1]) chg[i] = 1'b1;
      end
      r.pattern      = (eq_steps == n - 1) ? PAT_EQUAL : PAT_CONTIG;
      r.base_index   = v[0];
      r.change_mask  = chg;
      r.window_count = CNT_W'(1);
      r.mask_word    = '0;
      r.full_gather  = 1'b0;
      return r;
    end
    covered = 0;
    all_lanes = (1 << n) - 1;
    windows = 0;
    first_lo = 0;
    for (int i = 0; i < LANES; i++) offs[i] = 0;
    while (covered != all_lanes) begin
      lo = 64'hFFFF_FFFF_FFFF_FFFF;
      for (int i = 0; i < n; i++) begin
        if (!covered[i] && longint'(v[i]) < lo) lo = longint'(v[i]);
      end
      if (windows == 0) first_lo = lo;
      for (int i = 0; i < n; i++) begin
        if (!covered[i] && longint'(v[i]) < lo + n) begin
          offs[i] = int'(longint'(v[i]) - lo);
          covered |= 1 << i;
        end
      end
      windows++;
    end
    r.pattern = PAT_DISORDER;
    if (n > 4) begin
      r.mask_word = (windows == 1) ? MASK_W'(1) : MASK_W'(n);
    end else if (windows == 1) begin
      r.mask_word = MASK_W'((offs[0] & 'hF) | ((offs[1] & 'hF) << 4) |
                            ((offs[2] & 'hF) << 8) | ((offs[3] & 'hF) << 12));
    end else begin
      r.mask_word = MASK_W'(n);
    end
    r.base_index   = (windows == 1) ? idx_t'(first_lo) : v[0];
    r.change_mask  = LANES'(1);
    r.window_count = CNT_W'(windows);
    r.full_gather  = (windows > 1);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RES_W-1:0]);
        if (pending_results.size() == 0) begin
          $error("result beat with no classification pending: 0x%0h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("pattern", want.pattern, got.pattern);
          check_field("base_index", want.base_index, got.base_index);
          check_field("change_mask", want.change_mask, got.change_mask);
          check_field("window_count", want.window_count, got.window_count);
          check_field("mask_word", want.mask_word, got.mask_word);
          check_field("full_gather", want.full_gather, got.full_gather);
          check_field("pad", 0, out_tdata[OUT_W-1:RES_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.insert(pending_results.size(),
                               classify_indices(idx_vec_t'(in_tdata), lanes_cfg));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (out_stall_left > 0) begin
      out_tready <= 1'b0;
      out_stall_left--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall_left = pick_gap();
    end
  end

  task automatic send_vector(idx_vec_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_lanes(logic [CNT_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lanes_cfg = value;
  endtask

  function automatic idx_vec_t lanes8(idx_t l0, idx_t l1, idx_t l2, idx_t l3,
                                      idx_t l4, idx_t l5, idx_t l6, idx_t l7);
    idx_vec_t v;
    v[0] = l0;
    v[1] = l1;
    v[2] = l2;
    v[3] = l3;
    v[4] = l4;
    v[5] = l5;
    v[6] = l6;
    v[7] = l7;
    return v;
  endfunction

  function automatic idx_t pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return idx_t'($urandom_range(0, 15));
    if (r == 1) return idx_t'(31'h7FFF_FFFF - $urandom_range(0, 15));
    return idx_t'($urandom);
  endfunction

  function automatic idx_vec_t random_vector(int n);
    idx_vec_t v;
    idx_t     b;
    int       kind;
    int       span;
    int       lane;
    b = pick_base();
    kind = $urandom_range(0, 99);
    for (int i = 0; i < LANES; i++) v[i] = idx_t'($urandom);
    if (kind < 25) begin
      for (int i = 0; i < n; i++) v[i] = b;
    end else if (kind < 50) begin
      v[0] = b;
      for (int i = 1; i < n; i++) v[i] = v[i-1] + idx_t'($urandom_range(0, 1));
    end else if (kind < 75) begin
      for (int i = 0; i < n; i++) v[i] = b + idx_t'($urandom_range(0, n - 1));
    end else if (kind < 90) begin
      span = $urandom_range(n, 4 * n);
      for (int i = 0; i < n; i++) v[i] = b + idx_t'($urandom_range(0, span));
    end else if ($urandom_range(0, 1) == 0) begin
      v[$urandom_range(0, n - 1)] = 31'h7FFF_FFFF;
    end
    if (kind < 90 && $urandom_range(0, 9) == 0) begin
      lane = $urandom_range(0, n - 1);
      v[lane][$urandom_range(0, IDX_W - 1)] ^= 1'b1;
    end
    return v;
  endfunction

  task automatic test_reset_default();
    send_vector(lanes8(0, 1, 2, 3, 4, 5, 6, 7));
    send_vector(lanes8('1, '1, '1, '1, '1, '1, '1, '1));
    send_vector(lanes8(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_equal_contiguous();
    set_lanes(4'd8);
    send_vector(lanes8(5, 5, 6, 7, 7, 8, 9, 9));
    send_vector(lanes8(31'h7FFF_FFF9, 31'h7FFF_FFFA, 31'h7FFF_FFFB, 31'h7FFF_FFFC,
                       31'h7FFF_FFFD, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'h7FFF_FFFF));
    send_vector(lanes8(7, 6, 5, 4, 3, 2, 1, 0));
    send_vector(lanes8(0, 1, 2, 4, 5, 6, 7, 8));
  endtask

  task automatic test_disorder_windows();
    send_vector(lanes8(3, 0, 7, 1, 6, 2, 5, 4));
    send_vector(lanes8(0, 31'h7FFF_FFFF, 100, 50, 20, 10, 1000, 30));
    send_vector(lanes8(10, 2, 17, 9, 3, 25, 11, 40));
    send_vector(lanes8(2, 0, 0, 0, 0, 0, 0, 9));
  endtask

  task automatic test_lane_limits();
    set_lanes(4'd0);
    send_vector(lanes8(9, 123, 0, 31'h7FFF_FFFF, 4, 4, 4, 4));
    set_lanes(4'd1);
    send_vector(lanes8(31'h7FFF_FFFF, 0, 1, 2, 3, 4, 5, 6));
    set_lanes(4'd4);
    send_vector(lanes8(3, 1, 0, 2, 77, 0, 31'h7FFF_FFFF, 5));
    send_vector(lanes8(0, 1, 2, 0, 0, 0, 0, 0));
    send_vector(lanes8(0, 10, 20, 30, 1, 2, 3, 4));
    set_lanes(4'd3);
    send_vector(lanes8(2, 0, 1, 31'h7FFF_FFFF, 9, 9, 9, 9));
    set_lanes(4'd2);
    send_vector(lanes8(1, 0, 5, 5, 5, 5, 5, 5));
    set_lanes(4'd5);
    send_vector(lanes8(4, 0, 1, 2, 3, 100, 200, 300));
    set_lanes(4'd15);
    send_vector(lanes8(1, 1, 1, 1, 1, 1, 1, 2));
    send_vector(lanes8(0, 2, 4, 6, 8, 10, 12, 14));
  endtask

  task automatic test_random_streams();
    int n;
    for (int phase = 0; phase < 16; phase++) begin
      set_lanes(CNT_W'(phase));
      n = effective_lanes(CNT_W'(phase));
      for (int k = 0; k < 97; k++) begin
        if (k % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_vector(random_vector(n));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_default();
    test_equal_contiguous();
    test_disorder_windows();
    test_lane_limits();
    test_random_streams();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d classifications never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[gather_index_pattern_classifier] OK");
    end else begin
      $display("[gather_index_pattern_classifier] ERROR");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[gather_index_pattern_classifier] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/gipc_pkg.sv
sv/gipc_cmp_stage.sv
sv/gipc_sort_stage.sv
sv/gipc_win_stage.sv
sv/gipc_out_stage.sv
sv/gather_index_pattern_classifier.sv
tb/tb_gather_index_pattern_classifier.sv
